// ===== sv/ranked_top_n_score_table_core_defines.svh =====
// Assertion macros shared by the score table checker.
// Each macro samples on clk and is disabled while rst_n is low.
`ifndef RANKED_TOP_N_SCORE_TABLE_CORE_DEFINES_SVH
`define RANKED_TOP_N_SCORE_TABLE_CORE_DEFINES_SVH

// Condition must hold at every edge out of reset.
`define RTN_ASSERT_NOW(label, cond, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);

// Trigger implies the consequent in the next cycle.
`define RTN_ASSERT_NEXT(label, trig, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (trig) |=> (cons)) \
        else $error(msg);

`endif

// ===== sv/rtn_tbl_pkg.sv =====
// Shared types and constants for the ranked score table.
// No dependencies; imported by the cell and the top level.
`timescale 1ns / 1ps

package rtn_tbl_pkg;

    localparam int SCORE_W   = 16;
    localparam int RANK_W    = 4;
    localparam int TBL_SEL_W = 3;

    localparam logic OP_INSERT = 1'b0;
    localparam logic OP_READ   = 1'b1;

    typedef logic [SCORE_W-1:0] score_t;

    // Command broadcast to every cell in the chain
    typedef struct packed {
        logic                 ins;
        logic                 rot;
        logic [TBL_SEL_W-1:0] tbl;
    } cell_cmd_t;

endpackage

// ===== sv/rtn_tbl_cell.sv =====
// One position of the sorted chain: holds this rank's score for every table.
// Depends on rtn_tbl_pkg for the command struct and score type.
`timescale 1ns / 1ps

module rtn_tbl_cell #(
    parameter int TABLES = 3
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  rtn_tbl_pkg::cell_cmd_t cmd,
    input  rtn_tbl_pkg::score_t   new_score,
    input  logic                  prev_gt,
    input  rtn_tbl_pkg::score_t   prev_entry,
    input  rtn_tbl_pkg::score_t   next_entry,
    output rtn_tbl_pkg::score_t   entry,
    output logic                  gt
);
    import rtn_tbl_pkg::*;

    localparam int TID_W = (TABLES > 1) ? $clog2(TABLES) : 1;

    score_t            store_reg [TABLES];
    logic [TID_W-1:0]  sel;

    // Read the selected table's entry and compare against the offered score
    assign sel   = cmd.tbl[TID_W-1:0];
    assign entry = store_reg[sel];
    assign gt    = (new_score > entry);

    // Insert: take the score at the first greater position, else shift down.
    // Rotate: take the entry of the neighbor toward the tail.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int t = 0; t < TABLES; t++)
            begin
                store_reg[t] <= '0;
            end
        end
        else if (cmd.ins && gt)
        begin
            store_reg[sel] <= prev_gt ? prev_entry : new_score;
        end
        else if (cmd.rot)
        begin
            store_reg[sel] <= next_entry;
        end
    end

endmodule

// ===== sv/ranked_top_n_score_table_core.sv =====
// Ranked score table: ENTRIES-long chain of cells, each holding one rank of
// TABLES descending-sorted score tables. Sequencer and output register here.
// Depends on rtn_tbl_pkg and rtn_tbl_cell.
`timescale 1ns / 1ps

// Usage
//   Input stream (s_*): tuser = {table_id[1:0], operation}, tdata = new_score.
//   operation 0 inserts new_score into the table; one result comes back with
//   the 1-based rank where it landed, or 0 when it beat no entry (ties lose).
//   operation 1 reads the table: ENTRIES results, highest score first,
//   m_tlast on the final one. table_id at or above TABLES means the last table.
//   Output stream (m_*): tdata = {pad, entry_score, placed_rank}.
//   Sequence: an insert compares and shifts all cells in the accept cycle;
//   its rank is held in S_PUT and then loaded into the output register.
//   A read rotates the table one cell per cycle through the chain while the
//   output register is free. One item is in flight at a time; s_tready is high
//   only while the sequencer is idle.
//   Receiver stall: the output register holds its transfer and the chain
//   stops rotating until m_tready returns; a new item can still be accepted
//   while the last result of the previous one waits.
//   Reset clears every table to zero and empties the output register.
module ranked_top_n_score_table_core #(
    parameter int ENTRIES = 8,
    parameter int TABLES  = 3
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [15:0] s_tdata,   // [15:0] new_score
    input  logic [2:0]  s_tuser,   // [0] operation, [2:1] table_id
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [23:0] m_tdata,   // [3:0] placed_rank, [19:4] entry_score, [23:20] zero
    output logic        m_tlast
);
    import rtn_tbl_pkg::*;

    localparam int TID_W = (TABLES > 1) ? $clog2(TABLES) : 1;
    localparam int CNT_W = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
    localparam int RKX_W = ($clog2(ENTRIES + 2) > RANK_W) ? $clog2(ENTRIES + 2) : RANK_W;

    typedef enum logic [2:0] {
        S_IDLE = 3'b001,
        S_PUT  = 3'b010,
        S_READ = 3'b100
    } state_t;

    state_t              state_reg, state_next;
    logic [TID_W-1:0]    tid_reg, tid_next;
    logic [CNT_W-1:0]    cnt_reg, cnt_next;
    logic [RANK_W-1:0]   pend_rank_reg, pend_rank_next;

    logic                out_valid_reg, out_valid_next;
    logic [RANK_W-1:0]   out_rank_reg, out_rank_next;
    score_t              out_entry_reg, out_entry_next;
    logic                out_last_reg, out_last_next;

    logic                in_xfer;
    logic                out_free;
    logic                op_in;
    logic [TID_W-1:0]    sel_in;
    logic [RKX_W-1:0]    rank_x;
    logic                last_pos;
    cell_cmd_t           cmd;

    score_t              entry [ENTRIES];
    logic [ENTRIES-1:0]  gt;

    // Decode the input transfer
    assign s_tready = (state_reg == S_IDLE);
    assign in_xfer  = s_tvalid && s_tready;
    assign out_free = !out_valid_reg || m_tready;
    assign op_in    = s_tuser[0];
    assign sel_in   = (int'(s_tuser[2:1]) >= TABLES) ? TID_W'(TABLES - 1)
                                                     : TID_W'(s_tuser[2:1]);
    assign last_pos = (cnt_reg == CNT_W'(ENTRIES - 1));

    // Drive the cell chain
    always_comb
    begin
        cmd.ins = in_xfer && (op_in == OP_INSERT);
        cmd.rot = (state_reg == S_READ) && out_free;
        cmd.tbl = in_xfer ? TBL_SEL_W'(sel_in) : TBL_SEL_W'(tid_reg);
    end

    for (genvar i = 0; i < ENTRIES; i++)
    begin : g_cell
        rtn_tbl_cell #(
            .TABLES(TABLES)
        ) u_cell (
            .clk       (clk),
            .rst_n     (rst_n),
            .cmd       (cmd),
            .new_score (s_tdata),
            .prev_gt   ((i == 0) ? 1'b0 : gt[(i == 0) ? 0 : i - 1]),
            .prev_entry(entry[(i == 0) ? 0 : i - 1]),
            .next_entry(entry[(i == ENTRIES - 1) ? 0 : i + 1]),
            .entry     (entry[i]),
            .gt        (gt[i])
        );
    end

    // Rank from the greater flags; they are monotone along a sorted table
    assign rank_x = gt[ENTRIES-1] ? (RKX_W'(ENTRIES + 1) - RKX_W'($countones(gt)))
                                  : '0;

    // Sequence one item at a time and feed the output register
    always_comb
    begin
        state_next     = state_reg;
        tid_next       = tid_reg;
        cnt_next       = cnt_reg;
        pend_rank_next = pend_rank_reg;
        out_valid_next = out_valid_reg && !m_tready;
        out_rank_next  = out_rank_reg;
        out_entry_next = out_entry_reg;
        out_last_next  = out_last_reg;

        unique case (state_reg)
            S_IDLE:
            begin
                if (in_xfer)
                begin
                    tid_next       = sel_in;
                    cnt_next       = '0;
                    pend_rank_next = rank_x[RANK_W-1:0];
                    state_next     = (op_in == OP_INSERT) ? S_PUT : S_READ;
                end
            end
            S_PUT:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    out_rank_next  = pend_rank_reg;
                    out_entry_next = '0;
                    out_last_next  = 1'b1;
                    state_next     = S_IDLE;
                end
            end
            S_READ:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    out_rank_next  = '0;
                    out_entry_next = entry[0];
                    out_last_next  = last_pos;
                    cnt_next       = cnt_reg + 1'b1;
                    if (last_pos)
                    begin
                        state_next = S_IDLE;
                    end
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            cnt_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            cnt_reg       <= cnt_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        tid_reg       <= tid_next;
        pend_rank_reg <= pend_rank_next;
        out_rank_reg  <= out_rank_next;
        out_entry_reg <= out_entry_next;
        out_last_reg  <= out_last_next;
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {4'b0000, out_entry_reg, out_rank_reg};
    assign m_tlast  = out_last_reg;

endmodule

// ===== sv/rtn_tbl_chk.sv =====
// Port-level checker for the ranked score table, bound to the top level.
// Depends on ranked_top_n_score_table_core_defines.svh for assertion macros.
`timescale 1ns / 1ps
`include "ranked_top_n_score_table_core_defines.svh"

module rtn_tbl_chk #(
    parameter int ENTRIES = 8
) (
    input logic        clk,
    input logic        rst_n,
    input logic        s_tvalid,
    input logic        s_tready,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [23:0] m_tdata,
    input logic        m_tlast
);

    // A stalled result transfer holds its payload
    `RTN_ASSERT_NEXT(a_out_hold, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata) && $stable(m_tlast), "output changed while stalled")

    // One item at a time: ready drops right after an input transfer
    `RTN_ASSERT_NEXT(a_one_item, s_tvalid && s_tready, !s_tready, "input taken while busy")

    // Insert results carry no score, read results carry no rank; a rank ends its item
    `RTN_ASSERT_NOW(a_kind, !m_tvalid || m_tdata[3:0] == 4'd0 || (m_tdata[19:4] == 16'd0 && m_tlast), "rank and score both set")

    // Rank never points past the table
    `RTN_ASSERT_NOW(a_rank_max, !m_tvalid || ENTRIES > 15 || int'(m_tdata[3:0]) <= ENTRIES, "rank beyond table")

endmodule

bind ranked_top_n_score_table_core rtn_tbl_chk #(.ENTRIES(ENTRIES)) u_rtn_tbl_chk (.*);
